// ----- hdl/ecd_pkg.sv -----
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types and constants for the escape channel deframer.
// ----------------------------------------------------------------------------
package ecd_pkg;

    localparam int unsigned ECD_FIFO_DEPTH  = 4;
    localparam logic [7:0]  ECD_ESCAPE_INIT = 8'h01;

    // parse phase of the front end
    typedef enum logic [1:0] {
        PH_DATA   = 2'd0,
        PH_ESC    = 2'd1,
        PH_LEN_HI = 2'd2,
        PH_LEN_LO = 2'd3
    } phase_t;

    // kind of request handed from front to back
    typedef enum logic {
        CMD_PAYLOAD = 1'b0,
        CMD_HEADER  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data_byte;  // payload byte
        logic [7:0]  channel;    // header channel
        logic [15:0] length;     // header length
    } cmd_t;

endpackage

// ----- hdl/ecd_front.sv -----
// ----------------------------------------------------------------------------
// ecd_front
// Parses escape sequences and headers, turns payload bytes and complete headers into requests.
// ----------------------------------------------------------------------------
module ecd_front
    import ecd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output logic       in_ready,
    output logic       push,
    output cmd_t       push_cmd
);

    phase_t     phase_reg, phase_next;
    logic [7:0] escape_reg;
    logic [7:0] pending_reg;
    logic [7:0] len_hi_reg;
    logic       take;
    logic       is_esc;

    assign in_ready = !q_full;
    assign take     = in_valid && !q_full;
    assign is_esc   = (in_byte == escape_reg);

    // escape register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg <= ECD_ESCAPE_INIT;
        end else if (cfg_wr_en) begin
            escape_reg <= cfg_wr_data;
        end
    end

    // phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DATA;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // header bytes held until the length is complete
    always_ff @(posedge aclk) begin
        if (take && phase_reg == PH_ESC) begin
            pending_reg <= in_byte;
        end
        if (take && phase_reg == PH_LEN_HI) begin
            len_hi_reg <= in_byte;
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            unique case (phase_reg)
                PH_DATA:   phase_next = is_esc ? PH_ESC : PH_DATA;
                PH_ESC:    phase_next = (in_byte == 8'h00) ? PH_DATA : PH_LEN_HI;
                PH_LEN_HI: phase_next = PH_LEN_LO;
                PH_LEN_LO: phase_next = PH_DATA;
                default:   phase_next = PH_DATA;
            endcase
        end
    end

    // request toward the back end
    always_comb begin
        push               = 1'b0;
        push_cmd.kind      = CMD_PAYLOAD;
        push_cmd.data_byte = in_byte;
        push_cmd.channel   = pending_reg;
        push_cmd.length    = {len_hi_reg, in_byte};
        unique case (phase_reg)
            PH_DATA: begin
                push = take && !is_esc;
            end
            PH_ESC: begin
                // escape then zero is a literal escape byte
                push               = take && (in_byte == 8'h00);
                push_cmd.data_byte = escape_reg;
            end
            PH_LEN_HI: begin
                push = 1'b0;
            end
            PH_LEN_LO: begin
                push          = take;
                push_cmd.kind = CMD_HEADER;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/ecd_fifo.sv -----
// ----------------------------------------------------------------------------
// ecd_fifo
// Short request queue between the parser and the channel tracker.
// ----------------------------------------------------------------------------
module ecd_fifo
    import ecd_pkg::*;
#(
    parameter int unsigned DEPTH = ECD_FIFO_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/ecd_back.sv -----
// ----------------------------------------------------------------------------
// ecd_back
// Tracks channel and remaining length, drives the result register.
// ----------------------------------------------------------------------------
module ecd_back
    import ecd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [7:0] m_tuser,
    output logic       m_tlast
);

    logic [7:0]  channel_reg;
    logic [15:0] remain_reg;
    logic [15:0] remain_next;
    logic        valid_reg;
    logic [7:0]  data_reg;
    logic [7:0]  user_reg;
    logic        last_reg;
    logic        is_payload;

    assign q_pop       = q_not_empty && (!valid_reg || m_tready);
    assign is_payload  = (q_cmd.kind == CMD_PAYLOAD);
    assign remain_next = remain_reg - 16'd1;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // channel and count tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_reg <= '0;
            remain_reg  <= '0;
        end else if (q_pop) begin
            if (!is_payload) begin
                remain_reg  <= q_cmd.length;
                channel_reg <= (q_cmd.length == 16'd0) ? 8'd0 : q_cmd.channel;
            end else if (channel_reg != 8'd0) begin
                remain_reg <= remain_next;
                if (remain_next == 16'd0) begin
                    channel_reg <= 8'd0;
                end
            end
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop && is_payload) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (q_pop && is_payload) begin
            data_reg <= q_cmd.data_byte;
            user_reg <= channel_reg;
            last_reg <= (channel_reg != 8'd0) && (remain_next == 16'd0);
        end
    end

endmodule

// ----- hdl/escape_channel_deframer.sv -----
// ----------------------------------------------------------------------------
// escape_channel_deframer
// Path: a payload byte is written into the queue at the accepting edge and
// moves to the result register when the tracker pops it from the queue.
// Throughput: one byte per cycle unless the queue fills or the master side stalls.
// Reset: synchronous active-low; phase, channel, count and queue clear, the
// escape byte returns to 0x01.
// ----------------------------------------------------------------------------
module escape_channel_deframer
    import ecd_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = ECD_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,   // escape_byte
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] payload_byte
    output logic [7:0] m_tuser,       // [7:0] payload_channel
    output logic       m_tlast        // frame_last
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // parser
    ecd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_byte     (s_tdata),
        .q_full      (q_full),
        .in_ready    (s_tready),
        .push        (q_push),
        .push_cmd    (push_cmd)
    );

    // request queue
    ecd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // channel tracker and output
    ecd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
